/* design/ggfd_pkg.sv */
// ggfd_pkg: shared types and constants for the grid gradient block
// used by ggfd_ctrl, ggfd_datapath and the top level
`timescale 1ns / 1ps

package ggfd_pkg;

  // field widths
  localparam int COORD_W = 5;
  localparam int DATA_W  = 32;
  localparam int GRAD_W  = 40;
  localparam int RES_W   = 6;
  localparam int CFG_IDX_W = 2;

  // input kind codes
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Z = 2'd3;

  // configuration reset values
  localparam logic [RES_W-1:0]  RES_RESET = 6'd32;
  localparam logic [DATA_W-1:0] INV_RESET = 32'd65536;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // neighbor side codes
  localparam logic SIDE_HI = 1'b0;
  localparam logic SIDE_LO = 1'b1;

  // sequencing: six neighbor reads, then the diff/multiply/round pipe drains
  localparam logic [2:0] READ_LAST  = 3'd5;
  localparam logic [2:0] DRAIN_LAST = 3'd2;

  // saturation limits
  localparam logic [48:0] POS_LIM = 49'h00_7F_FFFF_FFFF;
  localparam logic [48:0] NEG_LIM = 49'h00_80_0000_0000;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;   // latch coordinates and the bad flag of the accepted item
    logic       load_wr;   // write the input value into the grid
    logic       rd_en;     // read one neighbor cell
    logic [1:0] rd_axis;
    logic       rd_side;
    logic       out_load;  // move the finished result into the output register
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bad;    // input coordinates fall outside the resolution
    logic query;  // input item is a gradient query
  } dp_stat_t;

endpackage

/* design/ggfd_ctrl.sv */
// ggfd_ctrl: sequencer for loads, neighbor reads and result hand-off
// depends on ggfd_pkg
`timescale 1ns / 1ps

module ggfd_ctrl import ggfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [2:0] step, step_next;
  logic       out_valid_next;

  // next state and commands
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.bad) begin
            state_next = ST_DONE;
          end else if (stat.query) begin
            state_next = ST_READ;
            step_next  = '0;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_axis = step[2:1];
        cmd.rd_side = step[0];
        if (step == READ_LAST) begin
          state_next = ST_DRAIN;
          step_next  = '0;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (step == DRAIN_LAST) begin
          state_next = ST_DONE;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* design/ggfd_datapath.sv */
// ggfd_datapath: config registers, grid memory, difference/scale pipe, result register
// depends on ggfd_pkg; driven by ggfd_ctrl commands
`timescale 1ns / 1ps

module ggfd_datapath import ggfd_pkg::*; #(
  parameter int MAX_RES = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     kind,
  input  logic [COORD_W-1:0]       coord_x,
  input  logic [COORD_W-1:0]       coord_y,
  input  logic [COORD_W-1:0]       coord_z,
  input  logic signed [DATA_W-1:0] value,
  input  ctl_cmd_t                 cmd,
  output dp_stat_t                 stat,
  output logic signed [GRAD_W-1:0] grad_x,
  output logic signed [GRAD_W-1:0] grad_y,
  output logic signed [GRAD_W-1:0] grad_z,
  output logic                     saturated,
  output logic                     bad_coord
);

  localparam int CELLS = MAX_RES * MAX_RES * MAX_RES;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = ($clog2(MAX_RES + 1) > RES_W) ? $clog2(MAX_RES + 1) : RES_W;
  localparam logic [RW-1:0] RES_MAX = RW'(MAX_RES);
  localparam logic [RW-1:0] RES_MIN = RW'(2);

  function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y,
                                              input logic [COORD_W-1:0] z);
    logic [31:0] a;
    a = 32'(x) * 32'(MAX_RES * MAX_RES) + 32'(y) * 32'(MAX_RES) + 32'(z);
    return a[AW-1:0];
  endfunction

  // configuration registers
  logic [RES_W-1:0]  res_reg;
  logic [DATA_W-1:0] inv_x, inv_y, inv_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_reg <= RES_RESET;
      inv_x   <= INV_RESET;
      inv_y   <= INV_RESET;
      inv_z   <= INV_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RESOLUTION: res_reg <= cfg_data[RES_W-1:0];
        REG_INV_STEP_X: inv_x   <= cfg_data;
        REG_INV_STEP_Y: inv_y   <= cfg_data;
        REG_INV_STEP_Z: inv_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  // resolution in use, clamped to [2, MAX_RES]
  logic [RW-1:0] res_use, res_last;

  always_comb begin
    res_use = RW'(res_reg);
    if (res_use < RES_MIN) begin
      res_use = RES_MIN;
    end else if (res_use > RES_MAX) begin
      res_use = RES_MAX;
    end
    res_last = res_use - RW'(1);
  end

  // coordinate check on the incoming item
  assign stat.bad = (RW'(coord_x) >= res_use) || (RW'(coord_y) >= res_use) ||
                    (RW'(coord_z) >= res_use);
  assign stat.query = (kind == KIND_QUERY);

  // captured coordinates and result working state
  logic [COORD_W-1:0] cap_x, cap_y, cap_z;
  logic               bad_w, sat_w;
  logic [GRAD_W-1:0]  gw_x, gw_y, gw_z;

  function automatic logic [COORD_W-1:0] axis_coord(input logic [1:0] axis,
                                                    input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y,
                                                    input logic [COORD_W-1:0] z);
    logic [COORD_W-1:0] c;
    case (axis)
      AXIS_X:  c = x;
      AXIS_Y:  c = y;
      default: c = z;
    endcase
    return c;
  endfunction

  // neighbor coordinates for the current read
  logic [COORD_W-1:0] rc, nc, nx, ny, nz;

  always_comb begin
    rc = axis_coord(cmd.rd_axis, cap_x, cap_y, cap_z);
    if (cmd.rd_side == SIDE_HI) begin
      nc = (RW'(rc) == res_last) ? rc : rc + COORD_W'(1);
    end else begin
      nc = (rc == '0) ? rc : rc - COORD_W'(1);
    end
    nx = cap_x;
    ny = cap_y;
    nz = cap_z;
    case (cmd.rd_axis)
      AXIS_X:  nx = nc;
      AXIS_Y:  ny = nc;
      default: nz = nc;
    endcase
  end

  // single-port grid memory
  logic [DATA_W-1:0] grid_mem [CELLS];
  logic [DATA_W-1:0] mem_q;
  logic [AW-1:0]     mem_addr;

  assign mem_addr = cmd.load_wr ? cell_addr(coord_x, coord_y, coord_z)
                                : cell_addr(nx, ny, nz);

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      grid_mem[mem_addr] <= value;
    end else if (cmd.rd_en) begin
      mem_q <= grid_mem[mem_addr];
    end
  end

  // read tag, follows the memory latency
  logic       rd_vld_q, rd_side_q;
  logic [1:0] rd_axis_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd.rd_en;
    end
    rd_axis_q <= cmd.rd_axis;
    rd_side_q <= cmd.rd_side;
  end

  // difference stage: hold the upper neighbor, subtract the lower one
  logic [DATA_W-1:0] hold_hi;
  logic signed [DATA_W:0] diff;
  logic [DATA_W:0]   diff_mag;
  logic [COORD_W-1:0] dc;
  logic              d_vld, d_neg, d_int;
  logic [1:0]        d_axis;
  logic [DATA_W:0]   d_mag;

  always_comb begin
    diff     = $signed({hold_hi[DATA_W-1], hold_hi}) - $signed({mem_q[DATA_W-1], mem_q});
    diff_mag = diff[DATA_W] ? 33'(-diff) : 33'(diff);
    dc       = axis_coord(rd_axis_q, cap_x, cap_y, cap_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= rd_vld_q && (rd_side_q == SIDE_LO);
    end
    if (rd_vld_q && (rd_side_q == SIDE_HI)) begin
      hold_hi <= mem_q;
    end
    d_neg  <= diff[DATA_W];
    d_mag  <= diff_mag;
    d_axis <= rd_axis_q;
    d_int  <= (dc != '0) && (RW'(dc) != res_last);
  end

  // multiply stage
  logic [DATA_W-1:0] inv_sel;
  logic [63:0]       prod_full;
  logic [63:0]       prod;
  logic              p_vld, p_neg, p_int;
  logic [1:0]        p_axis;

  always_comb begin
    case (d_axis)
      AXIS_X:  inv_sel = inv_x;
      AXIS_Y:  inv_sel = inv_y;
      default: inv_sel = inv_z;
    endcase
    // magnitude is at most 2^32, so the product stays below 2^64
    prod_full = 64'(d_mag) * 64'(inv_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= d_vld;
    end
    prod   <= prod_full;
    p_neg  <= d_neg;
    p_int  <= d_int;
    p_axis <= d_axis;
  end

  // round half away from zero, shift, saturate to 40 bits
  logic [64:0]       rsum, rshift;
  logic [48:0]       rmag;
  logic [GRAD_W-1:0] gval;
  logic              gsat;

  always_comb begin
    rsum   = 65'(prod) + (p_int ? (65'd1 << 16) : (65'd1 << 15));
    rshift = p_int ? (rsum >> 17) : (rsum >> 16);
    rmag   = rshift[48:0];
    gsat   = 1'b0;
    if (p_neg) begin
      if (rmag > NEG_LIM) begin
        rmag = NEG_LIM;
        gsat = 1'b1;
      end
      gval = GRAD_W'(~rmag + 49'd1);
    end else begin
      if (rmag > POS_LIM) begin
        rmag = POS_LIM;
        gsat = 1'b1;
      end
      gval = rmag[GRAD_W-1:0];
    end
  end

  // capture, per-axis result collection
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_x <= coord_x;
      cap_y <= coord_y;
      cap_z <= coord_z;
      bad_w <= stat.bad;
      sat_w <= 1'b0;
      gw_x  <= '0;
      gw_y  <= '0;
      gw_z  <= '0;
    end else if (p_vld) begin
      sat_w <= sat_w | gsat;
      case (p_axis)
        AXIS_X:  gw_x <= gval;
        AXIS_Y:  gw_y <= gval;
        default: gw_z <= gval;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      grad_x    <= gw_x;
      grad_y    <= gw_y;
      grad_z    <= gw_z;
      saturated <= sat_w;
      bad_coord <= bad_w;
    end
  end

endmodule

/* design/grid_gradient_finite_difference.sv */
// grid_gradient_finite_difference: top level, 3-D finite-difference gradient on a grid
// depends on ggfd_pkg, ggfd_ctrl, ggfd_datapath
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | kind, coord_x, coord_y, coord_z, value
//  out     | out_valid/out_ready  | grad_x, grad_y, grad_z, saturated, bad_coord
//
// a valid load keeps the input ready; a bad-coordinate item goes straight to hand-off
// a query blocks input until its result is in the output register: six reads of the
//   single-port grid memory, then the difference, multiply and round/saturate stages
// a result waiting in the output register does not block the next item until the
//   following result is ready to be handed over
// rst clears control and config; the grid memory is not cleared
`timescale 1ns / 1ps

module grid_gradient_finite_difference import ggfd_pkg::*; #(
  parameter int MAX_RES = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     kind,
  input  logic [COORD_W-1:0]       coord_x,
  input  logic [COORD_W-1:0]       coord_y,
  input  logic [COORD_W-1:0]       coord_z,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [GRAD_W-1:0] grad_x,
  output logic signed [GRAD_W-1:0] grad_y,
  output logic signed [GRAD_W-1:0] grad_z,
  output logic                     saturated,
  output logic                     bad_coord
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // configuration is always accepted
  assign cfg_ready = 1'b1;

  ggfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ggfd_datapath #(
    .MAX_RES (MAX_RES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .kind      (kind),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .grad_x    (grad_x),
    .grad_y    (grad_y),
    .grad_z    (grad_z),
    .saturated (saturated),
    .bad_coord (bad_coord)
  );

endmodule

/* design/ggfd_checker.sv */
// ggfd_checker: port-level assertions for the grid gradient block
// depends on ggfd_pkg; bound to grid_gradient_finite_difference
`timescale 1ns / 1ps

module ggfd_checker import ggfd_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     kind,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [GRAD_W-1:0] grad_x,
  input logic signed [GRAD_W-1:0] grad_y,
  input logic signed [GRAD_W-1:0] grad_z,
  input logic                     saturated,
  input logic                     bad_coord
);

  localparam logic [GRAD_W-1:0] G_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [GRAD_W-1:0] G_MIN = 40'h80_0000_0000;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(grad_x) && $stable(grad_y) &&
      $stable(grad_z) && $stable(saturated) && $stable(bad_coord))
    else $error("result changed while stalled");

  // a rejected coordinate carries no gradient
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_coord |-> grad_x == '0 && grad_y == '0 && grad_z == '0 && !saturated)
    else $error("bad coordinate result with nonzero payload");

  // a clipped result has at least one component at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> grad_x == G_MAX || grad_x == G_MIN || grad_y == G_MAX ||
      grad_y == G_MIN || grad_z == G_MAX || grad_z == G_MIN)
    else $error("saturated flag without a clipped component");

  // a query keeps the input side busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_QUERY |=> !in_ready)
    else $error("input accepted during a query");

endmodule

bind grid_gradient_finite_difference ggfd_checker u_ggfd_checker (.*);

/* verif/ggfd_sb_pkg.sv */
// ggfd_sb_pkg: gradient predictor and scoreboard for the grid gradient testbench
// depends on ggfd_pkg for field widths, kind codes and register indexes
`timescale 1ns / 1ps

package ggfd_sb_pkg;
  import ggfd_pkg::*;

  localparam int GRID_N     = 32;
  localparam int GRID_CELLS = GRID_N * GRID_N * GRID_N;

  // clip limits of a 40-bit signed gradient, as magnitudes
  localparam logic [64:0] CLIP_POS = 65'h7F_FFFF_FFFF;
  localparam logic [64:0] CLIP_NEG = 65'h80_0000_0000;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gz;
    logic                     sat;
    logic                     bad;
  } grad_t;

  class grad_scoreboard;
    logic [DATA_W-1:0] cells [GRID_CELLS];
    logic [RES_W-1:0]  res_reg;
    logic [DATA_W-1:0] inv_step [3];
    grad_t             grads_due [$];
    int n_checked;
    int n_errors;
    int n_queries;
    int n_bad;
    int n_sat;

    function new();
      res_reg = RES_RESET;
      foreach (inv_step[i]) inv_step[i] = INV_RESET;
      foreach (cells[i]) cells[i] = '0;
      n_checked = 0;
      n_errors  = 0;
      n_queries = 0;
      n_bad     = 0;
      n_sat     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_RESOLUTION: res_reg = data[RES_W-1:0];
        REG_INV_STEP_X: inv_step[AXIS_X] = data;
        REG_INV_STEP_Y: inv_step[AXIS_Y] = data;
        REG_INV_STEP_Z: inv_step[AXIS_Z] = data;
        default: ;
      endcase
    endfunction

    // out-of-range resolution settings clamp to [2, GRID_N]
    function int res_in_use();
      int r;
      r = res_reg;
      if (r < 2) r = 2;
      if (r > GRID_N) r = GRID_N;
      return r;
    endfunction

    function int cell_index(int x, int y, int z);
      return (x * GRID_N + y) * GRID_N + z;
    endfunction

    // |diff| * inv, shifted with round half away from zero, sign back on, clipped
    function logic [GRAD_W-1:0] scale_round_clip(logic signed [DATA_W:0] diff,
                                                 logic [DATA_W-1:0] inv, bit halve,
                                                 inout bit sat);
      logic [DATA_W:0] mag;
      logic [64:0]     prod;
      logic [64:0]     rounded;
      if (diff[DATA_W]) mag = -diff;
      else mag = diff;
      prod = {32'b0, mag} * {33'b0, inv};
      if (halve) rounded = (prod + (65'd1 << 16)) >> 17;
      else rounded = (prod + (65'd1 << 15)) >> 16;
      if (diff[DATA_W]) begin
        if (rounded > CLIP_NEG) begin
          rounded = CLIP_NEG;
          sat = 1'b1;
        end
        rounded = -rounded;
      end else if (rounded > CLIP_POS) begin
        rounded = CLIP_POS;
        sat = 1'b1;
      end
      return rounded[GRAD_W-1:0];
    endfunction

    // one-sided at either edge of the axis, central in between
    function logic [GRAD_W-1:0] axis_slope(int x, int y, int z, int axis, int r,
                                           inout bit sat);
      int lo [3];
      int hi [3];
      int pos;
      bit halve;
      logic signed [DATA_W:0] hi_val;
      logic signed [DATA_W:0] lo_val;
      lo = '{x, y, z};
      hi = '{x, y, z};
      pos = lo[axis];
      halve = 1'b0;
      if (pos == 0) begin
        hi[axis] = pos + 1;
      end else if (pos == r - 1) begin
        lo[axis] = pos - 1;
      end else begin
        lo[axis] = pos - 1;
        hi[axis] = pos + 1;
        halve = 1'b1;
      end
      hi_val = $signed(cells[cell_index(hi[0], hi[1], hi[2])]);
      lo_val = $signed(cells[cell_index(lo[0], lo[1], lo[2])]);
      return scale_round_clip(hi_val - lo_val, inv_step[axis], halve, sat);
    endfunction

    // accepted input transaction: update the grid or queue the expected gradient
    function void note_item(logic k, int x, int y, int z, logic [DATA_W-1:0] val);
      grad_t g;
      int r;
      bit sat;
      r = res_in_use();
      g = '0;
      sat = 1'b0;
      if (x >= r || y >= r || z >= r) begin
        g.bad = 1'b1;
        grads_due.push_back(g);
        n_bad++;
        return;
      end
      if (k == KIND_LOAD) begin
        cells[cell_index(x, y, z)] = val;
        return;
      end
      g.gx = axis_slope(x, y, z, int'(AXIS_X), r, sat);
      g.gy = axis_slope(x, y, z, int'(AXIS_Y), r, sat);
      g.gz = axis_slope(x, y, z, int'(AXIS_Z), r, sat);
      g.sat = sat;
      if (sat) n_sat++;
      n_queries++;
      grads_due.push_back(g);
    endfunction

    // accepted output transaction against the oldest expected gradient
    function void check_grad(logic [GRAD_W-1:0] gx, logic [GRAD_W-1:0] gy,
                             logic [GRAD_W-1:0] gz, logic sat, logic bad);
      grad_t want;
      grad_t got;
      got = '{gx, gy, gz, sat, bad};
      n_checked++;
      if (grads_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result: gx=%0d gy=%0d gz=%0d sat=%0b bad=%0b",
                   got.gx, got.gy, got.gz, got.sat, got.bad);
        return;
      end
      want = grads_due.pop_front();
      if (got.gx !== want.gx || got.gy !== want.gy || got.gz !== want.gz ||
          got.sat !== want.sat || got.bad !== want.bad) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("result %0d mismatch: expected gx=%0d gy=%0d gz=%0d sat=%0b bad=%0b",
                   n_checked, want.gx, want.gy, want.gz, want.sat, want.bad);
          $display("                      actual gx=%0d gy=%0d gz=%0d sat=%0b bad=%0b",
                   got.gx, got.gy, got.gz, got.sat, got.bad);
        end
      end
    endfunction

    function int pending();
      return grads_due.size();
    endfunction
  endclass

endpackage

/* verif/tb_top.sv */
// tb_top: self-checking testbench for grid_gradient_finite_difference
// depends on ggfd_pkg, ggfd_sb_pkg and the design files
`timescale 1ns / 1ps

module tb_top;
  import ggfd_pkg::*;
  import ggfd_sb_pkg::*;

  localparam int TARGET_ITEMS  = 1550;
  localparam int N_PHASES      = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     kind = KIND_LOAD;
  logic [COORD_W-1:0]       coord_x = '0;
  logic [COORD_W-1:0]       coord_y = '0;
  logic [COORD_W-1:0]       coord_z = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic signed [GRAD_W-1:0] grad_z;
  logic                     saturated;
  logic                     bad_coord;

  int   gap_pct = 0;
  int   stall_pct = 0;
  logic rx_hold = 1'b0;
  int   items_sent = 0;
  bit   written [GRID_CELLS];
  grad_scoreboard sb;

  grid_gradient_finite_difference dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver: check each output transaction, then stall at random or hold off
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_grad(grad_x, grad_y, grad_z, saturated, bad_coord);
    if (rst || rx_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // offer one input transaction after a random gap and wait for its acceptance
  task automatic send_item(logic k, int x, int y, int z, logic [DATA_W-1:0] v);
    int r;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    coord_x  <= x[COORD_W-1:0];
    coord_y  <= y[COORD_W-1:0];
    coord_z  <= z[COORD_W-1:0];
    value    <= v;
    do @(posedge clk); while (in_ready !== 1'b1);
    r = sb.res_in_use();
    sb.note_item(k, x, y, z, v);
    if (k == KIND_LOAD && x < r && y < r && z < r) written[sb.cell_index(x, y, z)] = 1'b1;
    items_sent++;
  endtask

  // sender stops offering until every expected gradient has come back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // registers change only once the block has gone quiet
  task automatic settle_and_program(logic [DATA_W-1:0] res_word, logic [DATA_W-1:0] ix,
                                    logic [DATA_W-1:0] iy, logic [DATA_W-1:0] iz);
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_RESOLUTION, res_word);
    write_reg(REG_INV_STEP_X, ix);
    write_reg(REG_INV_STEP_Y, iy);
    write_reg(REG_INV_STEP_Z, iz);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin gap_pct = 0;  stall_pct <= 0;  end
      IDLE_SENDER:   begin gap_pct = 85; stall_pct <= 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct <= 85; end
      default:       begin gap_pct = 24; stall_pct <= 24; end
    endcase
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return {{12{r[19]}}, r[19:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_inv();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return INV_RESET;
      3: return $urandom_range(32'h0004_0000, 32'h0000_1000);
      default: return $urandom;
    endcase
  endfunction

  // coordinates lean toward the edges so one-sided differences come up often
  function automatic int pick_coord(int r);
    case ($urandom_range(5))
      0: return 0;
      1: return r - 1;
      2: return (r > 2) ? 1 : 0;
      3: return (r > 2) ? r - 2 : r - 1;
      default: return $urandom_range(r - 1);
    endcase
  endfunction

  // load any cell the gradient at (x,y,z) reads that has never been written
  task automatic load_neighbors(int x, int y, int z);
    int c [3];
    int r;
    int pos;
    int lo;
    int hi;
    r = sb.res_in_use();
    for (int a = 0; a < 3; a++) begin
      c = '{x, y, z};
      pos = c[a];
      lo = (pos == 0) ? pos : pos - 1;
      hi = (pos == r - 1) ? pos : pos + 1;
      c[a] = lo;
      if (!written[sb.cell_index(c[0], c[1], c[2])])
        send_item(KIND_LOAD, c[0], c[1], c[2], pick_value());
      c[a] = hi;
      if (!written[sb.cell_index(c[0], c[1], c[2])])
        send_item(KIND_LOAD, c[0], c[1], c[2], pick_value());
    end
  endtask

  task automatic query_sequence(int x, int y, int z);
    load_neighbors(x, y, z);
    if ($urandom_range(2) == 0) send_item(KIND_LOAD, x, y, z, pick_value());
    send_item(KIND_QUERY, x, y, z, $urandom);
  endtask

  // at least one coordinate at or above the resolution, either kind
  task automatic bad_item(int r);
    int c [3];
    int a;
    c = '{$urandom_range(31), $urandom_range(31), $urandom_range(31)};
    a = $urandom_range(2);
    c[a] = $urandom_range(31, r);
    send_item(logic'($urandom_range(1)), c[0], c[1], c[2], $urandom);
  endtask

  task automatic random_step();
    int r;
    int sel;
    r = sb.res_in_use();
    sel = $urandom_range(99);
    if (sel < 60)
      query_sequence(pick_coord(r), pick_coord(r), pick_coord(r));
    else if (sel < 85 || r >= GRID_N)
      send_item(KIND_LOAD, pick_coord(r), pick_coord(r), pick_coord(r), pick_value());
    else
      bad_item(r);
  endtask

  task automatic directed_part();
    // far corner: backward differences with extreme values
    send_item(KIND_LOAD, 31, 31, 31, 32'h7FFF_FFFF);
    send_item(KIND_LOAD, 30, 31, 31, 32'h8000_0000);
    send_item(KIND_LOAD, 31, 30, 31, 32'h0000_0000);
    send_item(KIND_LOAD, 31, 31, 30, 32'hFFFF_FFFF);
    send_item(KIND_QUERY, 31, 31, 31, 32'h0);
    // origin: forward differences
    send_item(KIND_LOAD, 0, 0, 0, 32'h8000_0000);
    send_item(KIND_LOAD, 1, 0, 0, 32'h7FFF_FFFF);
    send_item(KIND_LOAD, 0, 1, 0, 32'h0001_0000);
    send_item(KIND_LOAD, 0, 0, 1, 32'h8000_0000);
    send_item(KIND_QUERY, 0, 0, 0, 32'hFFFF_FFFF);
    // small grid, largest x inverse step, zero y inverse step
    settle_and_program(32'd4, 32'hFFFF_FFFF, 32'h0, INV_RESET);
    send_item(KIND_QUERY, 0, 0, 0, 32'h0);
    // bad coordinates on both kinds
    send_item(KIND_LOAD, 4, 0, 0, 32'h1234_5678);
    send_item(KIND_QUERY, 0, 0, 31, 32'h0);
    send_item(KIND_LOAD, 3, 5, 1, 32'h7FFF_FFFF);
    // interior point: negative clip on x, rounding tie on z
    send_item(KIND_LOAD, 2, 1, 1, 32'h8000_0000);
    send_item(KIND_LOAD, 0, 1, 1, 32'h7FFF_FFFF);
    send_item(KIND_LOAD, 1, 2, 1, 32'h0000_0001);
    send_item(KIND_LOAD, 1, 0, 1, 32'h0000_0000);
    send_item(KIND_LOAD, 1, 1, 2, 32'h0000_0000);
    send_item(KIND_LOAD, 1, 1, 0, 32'h0000_0003);
    send_item(KIND_LOAD, 1, 1, 1, 32'h8000_0000);
    send_item(KIND_QUERY, 1, 1, 1, 32'h0);
  endtask

  initial begin
    logic [RES_W-1:0]  res_list [N_PHASES];
    logic [DATA_W-1:0] res_word;
    int  quota;
    int  half_mark;
    int  end_mark;
    bit  paused;
    sb = new();
    res_list = '{6'd32, 6'd2, 6'd63, 6'd7, 6'd0, 6'd31, 6'd45, 6'd1};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_part();

    // random phases, each with its own register setting and idling mode
    for (int p = 0; p < N_PHASES; p++) begin
      res_word = (p % 2 == 1) ? $urandom : 32'h0;
      res_word[RES_W-1:0] = (p == 5) ? RES_W'($urandom_range(30, 3)) : res_list[p];
      settle_and_program(res_word, pick_inv(), pick_inv(), pick_inv());
      set_idle(idle_mode_e'(p % 4));
      if (p == 0) begin
        // long receiver hold-off while the sender keeps offering
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
      end
      quota = (TARGET_ITEMS - items_sent) / (N_PHASES - p);
      half_mark = items_sent + quota / 2;
      end_mark = items_sent + quota;
      paused = 1'b0;
      while (items_sent < end_mark) begin
        random_step();
        if (!paused && items_sent >= half_mark) begin
          pause_until_drained();
          paused = 1'b1;
        end
      end
    end

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d items over %0d phases: %0d queries, %0d bad coordinates, %0d clipped",
             items_sent, N_PHASES, sb.n_queries, sb.n_bad, sb.n_sat);
    $display("%0d results checked, %0d mismatches", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("** grid_gradient_finite_difference: PASSED **");
    end else begin
      $display("** grid_gradient_finite_difference: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("** grid_gradient_finite_difference: FAILED **");
    $finish;
  end

endmodule
